// ----- rtl/gcga_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcga_pkg
// Types, constants and the exp table function shared by the coarse-graining
// accumulator modules.
// ----------------------------------------------------------------------------
package gcga_pkg;

  localparam int unsigned ExpRange = 16;

  typedef struct packed {
    logic               command;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] vel_z;
    logic signed [31:0] frc_x;
    logic signed [31:0] frc_y;
    logic signed [31:0] frc_z;
    logic        [15:0] atom_mass;
    logic               last_in_node;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] density_sum;
    logic signed [63:0] velocity_sum;
    logic signed [63:0] force_sum;
    logic               overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DSQ,
    ST_KERN,
    ST_TERMS,
    ST_SCALE,
    ST_ACC,
    ST_EMIT
  } state_t;

  // Q32.32 fractional multiply: exact product >> 32, truncated toward zero,
  // saturated when the magnitude reaches 2^63.
  typedef struct packed {
    logic signed [63:0] value;
    logic               sat;
  } mres_t;

  // Saturating signed add.
  function automatic mres_t sat_add(input logic signed [63:0] a,
                                    input logic signed [63:0] b);
    logic signed [63:0] s;
    mres_t r;
    s = a + b;
    r.value = s;
    r.sat = 1'b0;
    if (!a[63] && !b[63] && s[63]) begin
      r.value = 64'sh7FFF_FFFF_FFFF_FFFF;
      r.sat = 1'b1;
    end else if (a[63] && b[63] && !s[63]) begin
      r.value = 64'sh8000_0000_0000_0000;
      r.sat = 1'b1;
    end
    return r;
  endfunction

  // umul32 of the table build: (a * (b >> 1)) >> 31 on 64-bit values.
  function automatic logic [63:0] umul32(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * (b >> 1);
    return p >> 31;
  endfunction

  // Entry i of the exp table, evaluated at elaboration time.
  function automatic logic [32:0] exp_entry(input int unsigned size, input int unsigned i);
    logic [63:0] h;
    logic [63:0] term;
    logic [63:0] r;
    logic [63:0] e;
    h = (64'(ExpRange) << 32) / 64'(size);
    term = 64'h1_0000_0000;
    r = 64'h1_0000_0000;
    for (int n = 1; n <= 20; n++) begin
      term = umul32(term, h) / 64'(n);
      if ((n % 2) == 1) r = (r >= term) ? r - term : 64'd0;
      else r = r + term;
    end
    e = 64'h1_0000_0000;
    for (int unsigned k = 1; k <= i; k++) e = umul32(e, r);
    return e[32:0];
  endfunction

endpackage : gcga_pkg
`default_nettype wire

// ----- rtl/gcga_mul.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gcga_mul
// Shared Q32.32 multiplier. Operands are registered on start, the four
// 32x32 partial products are formed one per cycle, and the result is ready
// when done rises.
// ----------------------------------------------------------------------------
module gcga_mul (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic signed [63:0]   a,
  input  wire logic signed [63:0]   b,
  output gcga_pkg::mres_t           res,
  output logic                      done
);
  import gcga_pkg::*;

  logic [63:0]  ua;
  logic [63:0]  ub;
  logic         neg;
  logic [2:0]   step;
  logic         busy;
  logic [127:0] acc;
  logic [63:0]  pp;
  logic [31:0]  opa;
  logic [31:0]  opb;
  logic [127:0] ppw;
  logic [63:0]  mag;

  always_comb begin
    opa = step[0] ? ua[63:32] : ua[31:0];
    opb = step[1] ? ub[63:32] : ub[31:0];
    pp  = 64'(opa) * 64'(opb);
    ppw = 128'(pp) << (32 * (32'(step[0]) + 32'(step[1])));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        acc  <= '0;
        neg  <= a[63] ^ b[63];
        ua   <= a[63] ? 64'(-a) : 64'(a);
        ub   <= b[63] ? 64'(-b) : 64'(b);
      end else if (busy) begin
        acc  <= acc + ppw;
        step <= step + 3'd1;
        if (step == 3'd3) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    mag = acc[95:32];
    res.sat = (acc[127:96] != '0) || mag[63];
    if (res.sat) res.value = neg ? 64'sh8000_0000_0000_0000 : 64'sh7FFF_FFFF_FFFF_FFFF;
    else res.value = neg ? -$signed(mag) : $signed(mag);
  end

endmodule : gcga_mul
`default_nettype wire

// ----- rtl/gaussian_coarse_grain_accumulator.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// gaussian_coarse_grain_accumulator
// Gaussian kernel coarse-graining: accumulates density, velocity and force
// fields of grid nodes from a stream of atoms.
// ----------------------------------------------------------------------------
// Channel   Direction  Handshake           Payload
// in        input      in_valid/in_ready   in_item (gcga_pkg::in_item_t)
// out       output     out_valid/out_ready out_item (gcga_pkg::out_item_t)
// cfg       input      cfg_we              cfg_data (inv_resol_sq)
//
// A node item passes through ST_ACC. An atom item takes 9 multiplies per
// axis plus 3, one at a time in the one shared multiplier. Either kind also
// passes through ST_EMIT when it closes the node.
// Reset is synchronous; the exp table is a constant table with no sweep.
// in_ready is low while an item is worked on, and while a closed node waits
// for the result register to be taken.
// ----------------------------------------------------------------------------
module gaussian_coarse_grain_accumulator #(
  parameter int unsigned DIMENSIONS     = 3,
  parameter int unsigned EXP_TABLE_SIZE = 256
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire gcga_pkg::in_item_t  in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output gcga_pkg::out_item_t      out_item,
  input  wire logic                cfg_we,
  input  wire logic [31:0]         cfg_data
);
  import gcga_pkg::*;

  localparam int unsigned Dims   = (DIMENSIONS > 3) ? 3 : ((DIMENSIONS < 1) ? 1 : DIMENSIONS);
  localparam int unsigned IdxW   = $clog2(EXP_TABLE_SIZE);
  localparam int unsigned RangeW = $clog2(ExpRange);

  // Multiplier operations; OpQ runs between the OpDistSq and OpDistInv steps.
  localparam logic [3:0] OpDistSq    = 4'd0;
  localparam logic [3:0] OpDistInv   = 4'd1;
  localparam logic [3:0] OpVelDot    = 4'd2;
  localparam logic [3:0] OpFrcDot    = 4'd3;
  localparam logic [3:0] OpVelInv    = 4'd4;
  localparam logic [3:0] OpVelInvVel = 4'd5;
  localparam logic [3:0] OpVelSq     = 4'd6;
  localparam logic [3:0] OpDistInvSq = 4'd7;
  localparam logic [3:0] OpCross     = 4'd8;
  localparam logic [3:0] OpQ         = 4'd9;
  localparam logic [3:0] OpVelScale  = 4'd10;
  localparam logic [3:0] OpFrcScale  = 4'd11;

  typedef logic [32:0] tab_t [EXP_TABLE_SIZE];
  function automatic tab_t build_tab();
    tab_t t;
    for (int unsigned i = 0; i < EXP_TABLE_SIZE; i++) t[i] = exp_entry(EXP_TABLE_SIZE, i);
    return t;
  endfunction
  localparam tab_t ExpTab = build_tab();

  state_t state, state_next;

  logic [31:0]        inv_resol_sq;
  logic [31:0]        node_pos [3];
  logic signed [63:0] density_acc, velocity_acc, force_acc;
  logic               saturated_flag;
  in_item_t           item;

  logic signed [63:0] d [3];
  logic signed [63:0] dsq, inv, kern, vs, fs, t, a, vi, vv;
  logic               sat;
  logic [1:0]         axis;
  logic [3:0]         op;
  logic               mbusy;
  logic               emit_load;

  logic               mstart;
  logic signed [63:0] ma, mb;
  mres_t              mres;
  logic               mdone;

  gcga_mul u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .res(mres), .done(mdone)
  );

  function automatic logic signed [63:0] q32(input logic [31:0] x);
    return {{16{x[31]}}, x, 16'd0};
  endfunction

  function automatic logic signed [63:0] sel3(input logic [95:0] w, input logic [1:0] k);
    logic [31:0] x;
    x = (k == 2'd0) ? w[31:0] : ((k == 2'd1) ? w[63:32] : w[95:64]);
    return q32(x);
  endfunction

  logic signed [63:0] vk, fk;
  logic [IdxW-1:0]    idx;
  logic               far;
  always_comb begin
    vk  = sel3({item.vel_z, item.vel_y, item.vel_x}, axis);
    fk  = sel3({item.frc_z, item.frc_y, item.frc_x}, axis);
    far = dsq[63] || (dsq[63:32] >= 32'(ExpRange));
    // Table index of the q that the multiplier has just produced.
    idx = IdxW'((64'(mres.value[32 + RangeW - 1:0]) * 64'(EXP_TABLE_SIZE)) >> (32 + RangeW));
  end

  // Per axis: d*d first; then a=d*inv, a*v, a*f, v*inv, (v*inv)*v, v*v, a*a
  // and (v*v)*(a*a). Between them q=dsq*inv, and at the end vs*K and fs*K.
  always_comb begin
    ma = '0;
    mb = '0;
    case (op)
      OpDistSq:    begin ma = d[axis]; mb = d[axis]; end
      OpDistInv:   begin ma = d[axis]; mb = inv; end
      OpVelDot:    begin ma = a; mb = vk; end
      OpFrcDot:    begin ma = a; mb = fk; end
      OpVelInv:    begin ma = vk; mb = inv; end
      OpVelInvVel: begin ma = vi; mb = vk; end
      OpVelSq:     begin ma = vk; mb = vk; end
      OpDistInvSq: begin ma = a; mb = a; end
      OpCross:     begin ma = vv; mb = vi; end
      OpQ:         begin ma = dsq; mb = inv; end
      OpVelScale:  begin ma = vs; mb = kern; end
      default:     begin ma = fs; mb = kern; end
    endcase
  end

  assign mstart = mbusy == 1'b0 && (state == ST_DSQ || state == ST_KERN
                  || state == ST_TERMS || state == ST_SCALE);

  logic last_axis;
  assign last_axis = (axis == 2'(Dims - 1));

  // The closed node moves into the result register once that is free.
  assign emit_load = (state == ST_EMIT) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid && in_ready) state_next = in_item.command ? ST_DSQ : ST_ACC;
      ST_DSQ:   if (mdone && last_axis) state_next = ST_KERN;
      ST_KERN:  if (mdone) state_next = ST_TERMS;
      ST_TERMS: if (mdone && op == OpCross && last_axis) state_next = ST_SCALE;
      ST_SCALE: if (mdone && op == OpFrcScale) state_next = ST_ACC;
      ST_ACC:   state_next = item.last_in_node ? ST_EMIT : ST_IDLE;
      ST_EMIT:  if (emit_load) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (state == ST_IDLE);
  end

  mres_t s1, s2, s3, da, va, fa, sd, sv, sf;
  always_comb begin
    s1 = sat_add(t, -mres.value);
    s2 = sat_add(mres.value, mres.value);
    s3 = sat_add(t, s2.value);
    da = sat_add(density_acc, kern);
    va = sat_add(velocity_acc, vs);
    fa = sat_add(force_acc, fs);
    sd = sat_add(dsq, mres.value);
    sv = sat_add(vs, mres.value);
    sf = sat_add(fs, s3.value);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      inv_resol_sq <= 32'h0001_0000;
      for (int k = 0; k < 3; k++) node_pos[k] <= '0;
      density_acc <= '0;
      velocity_acc <= '0;
      force_acc <= '0;
      saturated_flag <= 1'b0;
      mbusy <= 1'b0;
      op <= OpDistSq;
      axis <= '0;
      out_valid <= 1'b0;
      out_item <= '0;
    end else begin
      state <= state_next;
      if (cfg_we) inv_resol_sq <= cfg_data;
      if (mstart) mbusy <= 1'b1;
      if (mdone) mbusy <= 1'b0;
      if (emit_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: if (in_valid) begin
          item <= in_item;
          inv  <= {16'd0, inv_resol_sq, 16'd0};
          dsq  <= '0; vs <= '0; fs <= '0; sat <= 1'b0;
          axis <= '0; op <= OpDistSq;
          for (int k = 0; k < 3; k++)
            d[k] <= q32(node_pos[k]) - sel3({in_item.pos_z, in_item.pos_y, in_item.pos_x}, 2'(k));
          if (!in_item.command) begin
            node_pos[0] <= in_item.pos_x;
            node_pos[1] <= in_item.pos_y;
            node_pos[2] <= in_item.pos_z;
          end
        end
        ST_DSQ: if (mdone) begin
          dsq <= sd.value;
          if (last_axis) op <= OpQ;
          else axis <= axis + 2'd1;
        end
        ST_KERN: if (mdone) begin
          dsq  <= mres.value;
          op   <= OpDistInv;
          axis <= '0;
        end
        ST_TERMS: if (mdone) begin
          case (op)
            OpDistInv: begin
              a   <= mres.value;
              sat <= sat | mres.sat;
            end
            OpVelDot: begin
              vs  <= sv.value;
              sat <= sat | mres.sat | sv.sat;
            end
            OpFrcDot: begin
              t   <= mres.value;
              sat <= sat | mres.sat;
            end
            OpVelInv: begin
              vi  <= mres.value;
              sat <= sat | mres.sat;
            end
            OpVelInvVel: begin
              t   <= s1.value;
              sat <= sat | mres.sat | s1.sat;
            end
            OpVelSq: begin
              vv  <= mres.value;
              sat <= sat | mres.sat;
            end
            OpDistInvSq: begin
              vi  <= mres.value;
              sat <= sat | mres.sat;
            end
            default: begin
              fs  <= sf.value;
              sat <= sat | mres.sat | s2.sat | s3.sat | sf.sat;
            end
          endcase
          if (op == OpCross) begin
            op   <= last_axis ? OpVelScale : OpDistInv;
            axis <= axis + 2'd1;
          end else begin
            op <= op + 4'd1;
          end
        end
        ST_SCALE: if (mdone) begin
          op <= op + 4'd1;
          if (op == OpVelScale) vs <= s2.value;
          else fs <= s2.value;
          sat <= sat | mres.sat | s2.sat;
        end
        ST_ACC: begin
          if (item.command) begin
            if (!far && kern != '0) begin
              density_acc <= da.value;
              velocity_acc <= va.value;
              force_acc <= fa.value;
              saturated_flag <= saturated_flag | sat | da.sat | va.sat | fa.sat;
            end
          end else begin
            density_acc <= '0;
            velocity_acc <= '0;
            force_acc <= '0;
            saturated_flag <= 1'b0;
          end
        end
        ST_EMIT: if (emit_load) begin
          out_item.density_sum  <= density_acc;
          out_item.velocity_sum <= velocity_acc;
          out_item.force_sum    <= force_acc;
          out_item.overflow     <= saturated_flag;
          density_acc <= '0;
          velocity_acc <= '0;
          force_acc <= '0;
          saturated_flag <= 1'b0;
        end
        default: ;
      endcase
      // Kernel is formed once q is known; it is zero for a far atom.
      if (state == ST_KERN && mdone)
        kern <= (mres.value[63] || mres.value[63:32] >= 32'(ExpRange)) ? 64'sd0
                : $signed(64'(item.atom_mass) * 64'(ExpTab[idx]));
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> !in_ready) else $error("input taken while busy");
  a_emit_only_last: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> item.last_in_node) else $error("result without last item");
  a_mul_single: assert property (@(posedge clk) disable iff (rst)
    mstart |=> !mstart) else $error("multiplier restarted");

endmodule : gaussian_coarse_grain_accumulator
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives grid node and atom items into the coarse-graining accumulator with
// random idling on both channels, predicts every node's three field sums and
// its overflow bit in a fixed-point model, and compares each result item.
// ----------------------------------------------------------------------------
module testbench;
  import gcga_pkg::*;

  localparam logic CMD_NODE = 1'b0;
  localparam logic CMD_ATOM = 1'b1;
  localparam int unsigned LUT_SIZE = 256;
  localparam logic [63:0] KERNEL_SPAN = 64'd16 << 32;
  localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;
  localparam int unsigned DRAIN_CYCLES = 300;
  localparam int unsigned STALL_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;

  gaussian_coarse_grain_accumulator u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_item(in_item),
    .out_valid(out_valid), .out_ready(out_ready), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  in_item_t pending_items[$];
  out_item_t expected_sums[$];
  int errors = 0;
  logic in_took = 1'b0;
  logic no_idle = 1'b0;
  logic hold_req = 1'b0;
  logic hold_done = 1'b0;
  int hold_left = 0;
  int quiet_cycles = 0;

  // Model state.
  logic [63:0] exp_lut[LUT_SIZE];
  logic [31:0] inv_sq = 32'd65536;
  logic [31:0] node_pos[3];
  logic signed [63:0] dens_acc, vel_acc, frc_acc;
  logic sum_sat;
  logic sat_seen;

  function automatic logic [63:0] q32_scale(input logic [63:0] a, input logic [63:0] b);
    logic [63:0] p;
    p = a * (b >> 1);
    return p >> 31;
  endfunction

  initial begin
    logic [63:0] step, term, ratio;
    step = KERNEL_SPAN / LUT_SIZE;
    term = 64'h1_0000_0000;
    ratio = 64'h1_0000_0000;
    for (int n = 1; n <= 20; n++) begin
      term = q32_scale(term, step) / 64'(n);
      if (n % 2 == 1) ratio = (ratio >= term) ? ratio - term : 64'd0;
      else ratio = ratio + term;
    end
    exp_lut[0] = 64'h1_0000_0000;
    for (int n = 1; n < LUT_SIZE; n++) exp_lut[n] = q32_scale(exp_lut[n - 1], ratio);
    node_pos = '{default: '0};
    dens_acc = 0;
    vel_acc = 0;
    frc_acc = 0;
    sum_sat = 1'b0;
  end

  function automatic logic signed [63:0] widen(input logic [31:0] raw);
    return $signed({{16{raw[31]}}, raw, 16'h0000});
  endfunction

  function automatic logic signed [63:0] qmul(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic neg;
    logic [63:0] ua, ub, r;
    logic [127:0] p;
    neg = a[63] ^ b[63];
    ua = a[63] ? 64'(-a) : a;
    ub = b[63] ? 64'(-b) : b;
    p = {64'd0, ua} * {64'd0, ub};
    if (p[127:95] != 0) begin
      sat_seen = 1'b1;
      return neg ? Q_MIN : Q_MAX;
    end
    r = p[95:32];
    return neg ? $signed(-r) : $signed(r);
  endfunction

  function automatic logic signed [63:0] qadd(input logic signed [63:0] a,
                                               input logic signed [63:0] b);
    logic signed [63:0] s;
    s = a + b;
    if (!a[63] && !b[63] && s[63]) begin
      sat_seen = 1'b1;
      return Q_MAX;
    end
    if (a[63] && b[63] && !s[63]) begin
      sat_seen = 1'b1;
      return Q_MIN;
    end
    return s;
  endfunction

  function automatic void add_atom(input in_item_t it);
    logic signed [63:0] d[3], v[3], f[3];
    logic signed [63:0] inv, dsq, q, kern, vs, fs, a, t;
    logic [31:0] apos[3], avel[3], afrc[3];
    logic [7:0] idx;
    apos = '{it.pos_x, it.pos_y, it.pos_z};
    avel = '{it.vel_x, it.vel_y, it.vel_z};
    afrc = '{it.frc_x, it.frc_y, it.frc_z};
    inv = $signed({16'h0000, inv_sq, 16'h0000});
    dsq = 0;
    for (int k = 0; k < 3; k++) begin
      d[k] = widen(node_pos[k]) - widen(apos[k]);
      v[k] = widen(avel[k]);
      f[k] = widen(afrc[k]);
      dsq = qadd(dsq, qmul(d[k], d[k]));
    end
    q = qmul(dsq, inv);
    if (q >= KERNEL_SPAN) return;
    idx = q[35:28];
    kern = 64'(it.atom_mass) * exp_lut[idx];
    if (kern == 0) return;
    // Saturation in the distance and exponent terms does not count.
    sat_seen = 1'b0;
    vs = 0;
    fs = 0;
    for (int k = 0; k < 3; k++) begin
      a = qmul(d[k], inv);
      vs = qadd(vs, qmul(a, v[k]));
      t = qmul(a, f[k]);
      t = qadd(t, -qmul(qmul(v[k], inv), v[k]));
      a = qmul(qmul(v[k], v[k]), qmul(a, a));
      t = qadd(t, qadd(a, a));
      fs = qadd(fs, t);
    end
    vs = qmul(vs, kern);
    vs = qadd(vs, vs);
    fs = qmul(fs, kern);
    fs = qadd(fs, fs);
    dens_acc = qadd(dens_acc, kern);
    vel_acc = qadd(vel_acc, vs);
    frc_acc = qadd(frc_acc, fs);
    if (sat_seen) sum_sat = 1'b1;
  endfunction

  function automatic void predict_node(input in_item_t it);
    out_item_t e;
    if (it.command == CMD_NODE) begin
      node_pos = '{it.pos_x, it.pos_y, it.pos_z};
      dens_acc = 0;
      vel_acc = 0;
      frc_acc = 0;
      sum_sat = 1'b0;
    end else begin
      add_atom(it);
    end
    if (it.last_in_node) begin
      e.density_sum = dens_acc;
      e.velocity_sum = vel_acc;
      e.force_sum = frc_acc;
      e.overflow = sum_sat;
      expected_sums.push_back(e);
      dens_acc = 0;
      vel_acc = 0;
      frc_acc = 0;
      sum_sat = 1'b0;
    end
  endfunction

  // Monitor: samples both channels at the rising edge.
  always @(posedge clk) begin
    out_item_t e;
    in_took = in_valid && in_ready;
    if (in_took) predict_node(in_item);
    if (out_valid && out_ready) begin
      if (expected_sums.size() == 0) begin
        $error("result item with no expectation pending");
        errors++;
      end else begin
        e = expected_sums.pop_front();
        if (out_item.density_sum !== e.density_sum) begin
          $error("density_sum expected %h actual %h", e.density_sum, out_item.density_sum);
          errors++;
        end
        if (out_item.velocity_sum !== e.velocity_sum) begin
          $error("velocity_sum expected %h actual %h", e.velocity_sum, out_item.velocity_sum);
          errors++;
        end
        if (out_item.force_sum !== e.force_sum) begin
          $error("force_sum expected %h actual %h", e.force_sum, out_item.force_sum);
          errors++;
        end
        if (out_item.overflow !== e.overflow) begin
          $error("overflow expected %b actual %b", e.overflow, out_item.overflow);
          errors++;
        end
      end
    end
    if (in_took || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("testbench: done, errors");
      $finish;
    end
  end

  // Driver.
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_items.size() > 0 && (no_idle || $urandom_range(99) >= 17)) begin
        in_item <= pending_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver, with one long hold-off so that the block backs up.
  always @(negedge clk) begin
    if (hold_req && !hold_done) begin
      hold_done <= 1'b1;
      hold_left <= 600;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= no_idle || $urandom_range(99) >= 17;
    end
  end

  function automatic in_item_t make_item(input logic cmd, input logic [31:0] px,
      input logic [31:0] py, input logic [31:0] pz, input logic [31:0] vv,
      input logic [31:0] ff, input logic [15:0] mass, input logic last);
    in_item_t it;
    it.command = cmd;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.vel_x = vv;
    it.vel_y = -vv;
    it.vel_z = vv >>> 1;
    it.frc_x = ff;
    it.frc_y = ~ff;
    it.frc_z = -ff;
    it.atom_mass = mass;
    it.last_in_node = last;
    return it;
  endfunction

  function automatic logic [31:0] motion_value();
    if ($urandom_range(3) == 0) return $urandom;
    return $urandom_range(0, 32'h0020_0000) - 32'h0010_0000;
  endfunction

  function automatic in_item_t random_atom(input logic [31:0] center[3],
                                           input int unsigned reach, input logic last);
    in_item_t it;
    it.command = CMD_ATOM;
    it.pos_x = center[0] + ($urandom_range(0, 2 * reach) - reach);
    it.pos_y = center[1] + ($urandom_range(0, 2 * reach) - reach);
    it.pos_z = center[2] + ($urandom_range(0, 2 * reach) - reach);
    it.vel_x = motion_value();
    it.vel_y = motion_value();
    it.vel_z = motion_value();
    it.frc_x = motion_value();
    it.frc_y = motion_value();
    it.frc_z = motion_value();
    it.atom_mass = 16'($urandom_range(0, 65535));
    it.last_in_node = last;
    return it;
  endfunction

  task automatic queue_nodes(input int count, input int unsigned reach);
    in_item_t it;
    logic [319:0] noise;
    logic [31:0] center[3];
    int sent, atoms, pick;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // Noise: every field random, command and last included.
        noise = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom, $urandom};
        it = noise[$bits(in_item_t)-1:0];
        pending_items.push_back(it);
        sent++;
      end else begin
        for (int k = 0; k < 3; k++)
          center[k] = ($urandom_range(9) == 0) ? $urandom
                                               : $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
        it = random_atom(center, 0, pick < 15);
        it.command = CMD_NODE;
        pending_items.push_back(it);
        sent++;
        if (pick >= 15) begin
          atoms = $urandom_range(1, 6);
          for (int a = 1; a <= atoms; a++) pending_items.push_back(random_atom(center, reach, a == atoms));
          sent += atoms;
        end
      end
    end
    // Close the phase with an empty node so the block ends idle.
    pending_items.push_back(make_item(CMD_NODE, 0, 0, 0, 0, 0, 0, 1'b1));
  endtask

  task automatic wait_idle();
    while (pending_items.size() > 0 || in_valid || expected_sums.size() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_resolution(input logic [31:0] value);
    wait_idle();
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we <= 1'b0;
    inv_sq = value;
  endtask

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    set_resolution(32'd65536);
    // Empty node, atom right on the node, far atom, massless atom, saturating atom.
    pending_items.push_back(make_item(CMD_NODE, 0, 0, 0, 0, 0, 0, 1'b1));
    pending_items.push_back(make_item(CMD_NODE, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                                      32'h1234_5678, 32'hDEAD_BEEF, 16'hFFFF, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h0001_0000, 32'h0002_0000, 32'hFFFD_0000,
                                      32'h0001_0000, 32'h0000_8000, 16'hFFFF, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h0065_0000, 32'h0002_0000, 32'hFFFD_0000,
                                      32'h0001_0000, 32'h0001_0000, 16'd1000, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h0001_8000, 32'h0002_0000, 32'hFFFD_0000,
                                      32'h0003_0000, 32'h0001_0000, 16'd0, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h0000_8000, 32'h0002_4000, 32'hFFFD_0000,
                                      32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 1'b1));
    // Atoms after an emission start a new node at the same position.
    pending_items.push_back(make_item(CMD_ATOM, 32'h0001_4000, 32'h0001_C000, 32'hFFFD_2000,
                                      32'h0002_0000, 32'hFFFF_0000, 16'd77, 1'b1));
    pending_items.push_back(make_item(CMD_NODE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      0, 0, 0, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'hFFFF_FFFF, 32'h0000_0001, 16'hFFFF, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                                      32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF, 1'b1));
    pending_items.push_back(make_item(CMD_NODE, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                      32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h8000_0000, 32'h8000_0001, 32'h8000_0000,
                                      32'h8000_0000, 32'h8000_0000, 16'hFFFF, 1'b1));
    // A node item in the middle of a node clears the sums gathered so far.
    pending_items.push_back(make_item(CMD_NODE, 32'h0010_0000, 0, 0, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h0010_8000, 0, 0,
                                      32'h0001_0000, 32'h0001_0000, 16'd500, 1'b0));
    pending_items.push_back(make_item(CMD_NODE, 32'h0020_0000, 0, 0, 0, 0, 0, 1'b0));
    pending_items.push_back(make_item(CMD_ATOM, 32'h0020_4000, 32'h0000_4000, 0,
                                      32'h0000_4000, 32'hFFFF_C000, 16'd900, 1'b1));

    hold_req = 1'b1;
    queue_nodes(500, 200000);

    set_resolution(32'd0);
    queue_nodes(200, 32'h4000_0000);

    set_resolution(32'hFFFF_FFFF);
    queue_nodes(250, 300);

    set_resolution(32'd1);
    no_idle = 1'b1;
    queue_nodes(250, 32'h0400_0000);
    wait_idle();
    no_idle = 1'b0;

    set_resolution($urandom);
    queue_nodes(300, 100000);

    set_resolution(32'd4096);
    queue_nodes(350, 800000);

    wait_idle();
    if (errors == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule
`default_nettype wire
